### src/barb_pkg.sv
package barb_pkg;

	localparam int SEQ_W = 12;
	localparam int HANDLE_W = 32;
	localparam int TICK_W = 32;
	localparam int WS_W = 7;
	localparam int TO_W = 8;
	localparam int CFG_W = 12;
	localparam int CFG_IDX_W = 2;
	localparam int DEF_MAX_WINDOW = 64;
	localparam logic [WS_W-1:0] DEF_WINDOW = 7'd64;
	localparam logic [TO_W-1:0] DEF_TIMEOUT = 8'd5;
	localparam logic [SEQ_W-1:0] SEQ_HALF = 12'h800;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_SIZE = 2'd0,
		REG_START_SEQ   = 2'd1,
		REG_TIMEOUT     = 2'd2
	} reg_index_t;

	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_TICK = 1'b1;
	localparam logic DISP_DELIVER = 1'b0;
	localparam logic DISP_DROP = 1'b1;

	typedef struct packed {
		logic load;
		logic emit_now;
		logic emit_drop;
		logic emit_rd;
		logic head_step;
		logic head_jump;
		logic head_add_skip;
		logic rel_head;
		logic rd_j;
		logic rel_j;
		logic store;
		logic scan_init;
		logic scan_skip;
		logic scan_next;
		logic mod_head;
		logic mod_seq;
		logic set_head_idx;
		logic set_seq_idx;
		logic flush;
	} barb_cmd_t;

	typedef struct packed {
		logic seq_stale;
		logic seq_ahead;
		logic ru_more;
		logic count_zero;
		logic head_full;
		logic seq_full;
		logic seq_is_head;
		logic j_full;
		logic j_at_head;
		logic skip_nonzero;
		logic timed_out;
		logic mod_done;
	} barb_stat_t;

	function automatic logic seq_before(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] d;
		d = a - b;
		return d > SEQ_HALF;
	endfunction

endpackage

### src/barb_mod.sv
module barb_mod import barb_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW,
	parameter int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
	parameter int SZ_W = $clog2(MAX_WINDOW + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [SEQ_W-1:0] dividend,
	input  logic [SZ_W-1:0]  divisor,
	output logic [IDX_W-1:0] remainder,
	output logic             done
);

	localparam int CNT_W = $clog2(SEQ_W + 1);

	logic [SZ_W-1:0]  rem_q;
	logic [SEQ_W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [SZ_W:0]    trial;
	logic [SZ_W:0]    dsor;

	assign trial = {rem_q, div_q[SEQ_W-1]};
	assign dsor = {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (go) begin
			cnt_q <= CNT_W'(SEQ_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			div_q <= dividend;
		end else if (cnt_q != '0) begin
			if (trial >= dsor) begin
				rem_q <= SZ_W'(trial - dsor);
			end else begin
				rem_q <= SZ_W'(trial);
			end
			div_q <= {div_q[SEQ_W-2:0], 1'b0};
		end
	end

	assign remainder = IDX_W'(rem_q);
	assign done = done_q;

endmodule

### src/barb_dp.sv
module barb_dp import barb_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  barb_cmd_t            cmd,
	output barb_stat_t           stat,
	input  logic                 command,
	input  logic [SEQ_W-1:0]     seq_num,
	input  logic [HANDLE_W-1:0]  frame_handle,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output logic [HANDLE_W-1:0]  out_handle,
	output logic                 disposition,
	output logic                 last,
	output logic                 result_strobe
);

	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SZ_W = $clog2(MAX_WINDOW + 1);

	logic [WS_W-1:0]     ws_q;
	logic [SEQ_W-1:0]    start_q;
	logic [TO_W-1:0]     timeout_q;
	logic [SEQ_W-1:0]    head_off_q;
	logic [IDX_W-1:0]    head_idx_q;
	logic [MAX_WINDOW-1:0] full_q;
	logic [SZ_W-1:0]     count_q;
	logic [TICK_W-1:0]   tick_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [IDX_W-1:0]    seq_idx_q;
	logic [IDX_W-1:0]    j_q;
	logic [SZ_W-1:0]     skip_q;
	logic                pv_q;
	logic [HANDLE_W-1:0] ph_q;
	logic                pd_q;
	logic                strobe_q;
	logic [HANDLE_W-1:0] oh_q;
	logic                od_q;
	logic                ol_q;

	logic [HANDLE_W+TICK_W-1:0] mem [MAX_WINDOW];
	logic [HANDLE_W+TICK_W-1:0] rd_q;

	logic [SZ_W-1:0]     size;
	logic [SEQ_W-1:0]    head;
	logic [SEQ_W-1:0]    target;
	logic [SEQ_W-1:0]    seq_off;
	logic [SEQ_W-1:0]    step_off;
	logic [IDX_W-1:0]    step_idx;
	logic [IDX_W-1:0]    j_next;
	logic [SZ_W-1:0]     head_inc;
	logic [SZ_W-1:0]     j_inc;
	logic [TICK_W-1:0]   age;
	logic                restart;
	logic                new_res;
	logic [HANDLE_W-1:0] new_h;
	logic                new_d;
	logic [IDX_W-1:0]    rd_addr;
	logic                mod_go;
	logic [IDX_W-1:0]    mod_rem;
	logic                mod_done;

	function automatic logic [IDX_W-1:0] step_idx_scan(input logic [IDX_W-1:0] i,
		input logic [SZ_W-1:0] sz);
		logic [SZ_W-1:0] n;
		n = SZ_W'(i) + SZ_W'(1);
		return (n == sz) ? '0 : IDX_W'(n);
	endfunction

	always_comb begin
		if (ws_q == '0) begin
			size = SZ_W'(1);
		end else if (ws_q > WS_W'(MAX_WINDOW)) begin
			size = SZ_W'(MAX_WINDOW);
		end else begin
			size = SZ_W'(ws_q);
		end
	end

	assign head = start_q + head_off_q;
	assign target = seq_q - SEQ_W'(size) + SEQ_W'(1);
	assign seq_off = seq_q - start_q;
	assign step_off = head_off_q + SEQ_W'(1);
	assign head_inc = SZ_W'(head_idx_q) + SZ_W'(1);
	assign j_inc = SZ_W'(j_q) + SZ_W'(1);
	assign step_idx = (step_off == '0 || head_inc == size) ? '0 : IDX_W'(head_inc);
	assign j_next = (j_inc == size) ? '0 : IDX_W'(j_inc);
	assign age = rd_q[TICK_W-1:0] + TICK_W'(timeout_q) - tick_q;
	assign restart = wr_en && (wr_index == REG_WINDOW_SIZE || wr_index == REG_START_SEQ);
	assign mod_go = cmd.mod_head || cmd.mod_seq;
	assign rd_addr = cmd.rel_head ? head_idx_q : j_q;

	barb_mod #(.MAX_WINDOW(MAX_WINDOW), .IDX_W(IDX_W), .SZ_W(SZ_W)) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (mod_go),
		.dividend  (cmd.mod_head ? head_off_q : seq_off),
		.divisor   (size),
		.remainder (mod_rem),
		.done      (mod_done)
	);

	always_comb begin
		stat.seq_stale = seq_before(seq_q, head);
		stat.seq_ahead = !seq_before(seq_q, head + SEQ_W'(size));
		stat.ru_more = seq_before(head, target);
		stat.count_zero = (count_q == '0);
		stat.head_full = full_q[head_idx_q];
		stat.seq_full = full_q[seq_idx_q];
		stat.seq_is_head = (seq_q == head);
		stat.j_full = full_q[j_q];
		stat.j_at_head = (j_q == head_idx_q);
		stat.skip_nonzero = (skip_q != '0);
		stat.timed_out = age[TICK_W-1];
		stat.mod_done = mod_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= DEF_WINDOW;
			start_q <= '0;
			timeout_q <= DEF_TIMEOUT;
			head_off_q <= '0;
			head_idx_q <= '0;
			full_q <= '0;
			count_q <= '0;
			tick_q <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_WINDOW_SIZE: ws_q <= wr_data[WS_W-1:0];
					REG_START_SEQ:   start_q <= wr_data[SEQ_W-1:0];
					REG_TIMEOUT:     timeout_q <= wr_data[TO_W-1:0];
					default: ;
				endcase
			end
			if (restart) begin
				head_off_q <= '0;
				head_idx_q <= '0;
				full_q <= '0;
				count_q <= '0;
			end else begin
				if (cmd.head_step) begin
					head_off_q <= step_off;
					head_idx_q <= step_idx;
				end else if (cmd.head_jump) begin
					head_off_q <= target - start_q;
				end else if (cmd.head_add_skip) begin
					head_off_q <= head_off_q + SEQ_W'(skip_q) + SEQ_W'(1);
				end
				if (cmd.set_head_idx) begin
					head_idx_q <= mod_rem;
				end
				if (cmd.rel_head) begin
					full_q[head_idx_q] <= 1'b0;
					count_q <= count_q - SZ_W'(1);
				end else if (cmd.rel_j) begin
					full_q[j_q] <= 1'b0;
					count_q <= count_q - SZ_W'(1);
				end else if (cmd.store) begin
					full_q[seq_idx_q] <= 1'b1;
					count_q <= count_q + SZ_W'(1);
				end
			end
			if (cmd.load && command == CMD_TICK) begin
				tick_q <= tick_q + TICK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q <= seq_num;
			handle_q <= frame_handle;
		end
		if (cmd.set_seq_idx) begin
			seq_idx_q <= mod_rem;
		end
		if (cmd.scan_init) begin
			j_q <= step_idx_scan(head_idx_q, size);
			skip_q <= SZ_W'(1);
		end else if (cmd.scan_skip) begin
			j_q <= j_next;
			skip_q <= skip_q + SZ_W'(1);
		end else if (cmd.scan_next) begin
			j_q <= j_next;
			skip_q <= '0;
		end
		if (cmd.store) begin
			mem[seq_idx_q] <= {handle_q, tick_q};
		end
		if (cmd.rel_head || cmd.rd_j) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_comb begin
		new_res = cmd.emit_now || cmd.emit_rd;
		if (cmd.emit_rd) begin
			new_h = rd_q[HANDLE_W+TICK_W-1:TICK_W];
			new_d = DISP_DELIVER;
		end else begin
			new_h = handle_q;
			new_d = cmd.emit_drop ? DISP_DROP : DISP_DELIVER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (new_res) begin
				pv_q <= 1'b1;
				strobe_q <= pv_q;
			end else if (cmd.flush) begin
				pv_q <= 1'b0;
				strobe_q <= pv_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (new_res) begin
			ph_q <= new_h;
			pd_q <= new_d;
			oh_q <= ph_q;
			od_q <= pd_q;
			ol_q <= 1'b0;
		end else if (cmd.flush) begin
			oh_q <= ph_q;
			od_q <= pd_q;
			ol_q <= 1'b1;
		end
	end

	assign out_handle = oh_q;
	assign disposition = od_q;
	assign last = ol_q;
	assign result_strobe = strobe_q;

endmodule

### src/barb_ctrl.sv
module barb_ctrl import barb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       command,
	input  barb_stat_t stat,
	output barb_cmd_t  cmd,
	output logic       busy
);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_RU, S_RU_RD, S_SMOD, S_SWAIT, S_ARR, S_RUN,
		S_IO, S_IO_RD, S_SCAN, S_SCAN_RD, S_HMOD, S_HWAIT, S_FIN
	} state_t;

	state_t state_q;
	state_t nxt;
	logic   ret_seq_q;
	logic   ret_seq_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_seq_q <= 1'b0;
		end else begin
			state_q <= nxt;
			ret_seq_q <= ret_seq_d;
		end
	end

	always_comb begin
		cmd = '0;
		nxt = state_q;
		ret_seq_d = ret_seq_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					nxt = (command == CMD_TICK) ? S_RUN : S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.seq_stale) begin
					cmd.emit_now = 1'b1;
					cmd.emit_drop = 1'b1;
					nxt = S_FIN;
				end else if (stat.seq_ahead) begin
					nxt = S_RU;
				end else begin
					nxt = S_SMOD;
				end
			end
			S_RU: begin
				if (!stat.ru_more) begin
					nxt = S_SMOD;
				end else if (stat.count_zero) begin
					cmd.head_jump = 1'b1;
					ret_seq_d = 1'b1;
					nxt = S_HMOD;
				end else if (stat.head_full) begin
					cmd.rel_head = 1'b1;
					cmd.head_step = 1'b1;
					nxt = S_RU_RD;
				end else begin
					cmd.head_step = 1'b1;
				end
			end
			S_RU_RD: begin
				cmd.emit_rd = 1'b1;
				nxt = S_RU;
			end
			S_SMOD: begin
				cmd.mod_seq = 1'b1;
				nxt = S_SWAIT;
			end
			S_SWAIT: begin
				if (stat.mod_done) begin
					cmd.set_seq_idx = 1'b1;
					nxt = S_ARR;
				end
			end
			S_ARR: begin
				if (stat.seq_full) begin
					cmd.emit_now = 1'b1;
					cmd.emit_drop = 1'b1;
					nxt = S_FIN;
				end else if (stat.seq_is_head && stat.count_zero) begin
					cmd.head_step = 1'b1;
					cmd.emit_now = 1'b1;
					nxt = S_FIN;
				end else begin
					cmd.store = 1'b1;
					nxt = S_RUN;
				end
			end
			S_RUN: begin
				if (!stat.head_full && !stat.count_zero) begin
					cmd.scan_init = 1'b1;
					nxt = S_SCAN;
				end else begin
					nxt = S_IO;
				end
			end
			S_IO: begin
				if (stat.head_full) begin
					cmd.rel_head = 1'b1;
					cmd.head_step = 1'b1;
					nxt = S_IO_RD;
				end else begin
					nxt = S_FIN;
				end
			end
			S_IO_RD: begin
				cmd.emit_rd = 1'b1;
				nxt = S_IO;
			end
			S_SCAN: begin
				if (stat.j_at_head) begin
					ret_seq_d = 1'b0;
					nxt = S_HMOD;
				end else if (stat.j_full) begin
					cmd.rd_j = 1'b1;
					nxt = S_SCAN_RD;
				end else begin
					cmd.scan_skip = 1'b1;
				end
			end
			S_SCAN_RD: begin
				if (stat.skip_nonzero && !stat.timed_out) begin
					ret_seq_d = 1'b0;
					nxt = S_HMOD;
				end else begin
					cmd.rel_j = 1'b1;
					cmd.emit_rd = 1'b1;
					cmd.head_add_skip = 1'b1;
					cmd.scan_next = 1'b1;
					nxt = S_SCAN;
				end
			end
			S_HMOD: begin
				cmd.mod_head = 1'b1;
				nxt = S_HWAIT;
			end
			S_HWAIT: begin
				if (stat.mod_done) begin
					cmd.set_head_idx = 1'b1;
					nxt = ret_seq_q ? S_SMOD : S_FIN;
				end
			end
			S_FIN: begin
				cmd.flush = 1'b1;
				nxt = S_IDLE;
			end
			default: nxt = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

### src/block_ack_rx_reorder_buffer_top.sv
// Receive reorder window for one block-ack session.
// An item is taken when start is high and busy is low: command selects a
// frame arrival (seq_num, frame_handle) or a tick. Each word that leaves the
// block is shown for one cycle with result_strobe high and carries the frame
// handle, its disposition (deliver or drop) and last on the final word of
// the item. The receiver cannot stall, so words are never held back.
// The work per item varies: a stale frame's drop word is strobed once the
// check and flush states have run, a slot index needs a sequential modulo
// by the window size, each released frame is read through the registered
// slot memory, and a timeout scan walks the window one slot per cycle,
// pausing to read each stored frame, and ends with another modulo. One item
// is in flight at a time; a long window slide steps through each skipped
// sequence number while frames remain stored. Configuration is written
// through wr_en, wr_index and wr_data while busy is low; the user must keep
// to this, as the block does not enforce it. Writing the window size or
// start sequence restarts the session. Reset empties all slots, sets the
// window head to the start sequence and clears the tick count.
module block_ack_rx_reorder_buffer_top import barb_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 command,
	input  logic [SEQ_W-1:0]     seq_num,
	input  logic [HANDLE_W-1:0]  frame_handle,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output logic [HANDLE_W-1:0]  out_handle,
	output logic                 disposition,
	output logic                 last,
	output logic                 result_strobe
);

	barb_cmd_t  cmd;
	barb_stat_t stat;

	barb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	barb_dp #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.command       (command),
		.seq_num       (seq_num),
		.frame_handle  (frame_handle),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.out_handle    (out_handle),
		.disposition   (disposition),
		.last          (last),
		.result_strobe (result_strobe)
	);

	a_drop_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && disposition |-> last)
		else $error("A dropped frame was not the final word of its item.");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last |=> !result_strobe)
		else $error("A word followed the final word of an item.");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !result_strobe && busy)
		else $error("An accepted item did not start cleanly.");

endmodule
